### rtl/tksi_pkg.sv
// Shared types and constants for the top-k sorted insertion list.
`timescale 1ns / 1ps
package tksi_pkg;

   localparam int SLOTS = 10;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic        command;
      logic [63:0] new_value;
      logic [62:0] new_timestamp;
      logic [3:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        was_inserted;
      logic [3:0]  insert_slot;
      logic [3:0]  valid_count;
      logic [63:0] entry_value;
      logic [62:0] entry_timestamp;
      logic        entry_valid;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] value;
      logic [62:0] stamp;
   } slot_type;

endpackage

### rtl/tksi_cell.sv
// One slot of the list: compares against the new value and shifts from its upper neighbor.
`timescale 1ns / 1ps
module tksi_cell import tksi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     add_en,
   input  slot_type new_entry,
   input  logic     prev_take,
   input  slot_type prev_entry,
   output logic     take,
   output slot_type entry
);

   slot_type entry_ff;
   slot_type entry_in;

   // empty slot or strictly smaller value; strict compare keeps the older tie ahead
   assign take  = !entry_ff.valid || (new_entry.value > entry_ff.value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (add_en) begin
         if (prev_take) begin
            entry_in = prev_entry;
         end else if (take) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/tksi_chain.sv
// Row of slot cells, highest value in cell 0.
`timescale 1ns / 1ps
module tksi_chain import tksi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             add_en,
   input  slot_type         new_entry,
   output logic [SLOTS-1:0] take,
   output slot_type         entries [SLOTS]
);

   genvar i;
   generate
      for (i = 0; i < SLOTS; i++) begin : g_cell
         if (i == 0) begin : g_head
            tksi_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .add_en     (add_en),
               .new_entry  (new_entry),
               .prev_take  (1'b0),
               .prev_entry (new_entry),
               .take       (take[i]),
               .entry      (entries[i])
            );
         end else begin : g_body
            tksi_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .add_en     (add_en),
               .new_entry  (new_entry),
               .prev_take  (take[i-1]),
               .prev_entry (entries[i-1]),
               .take       (take[i]),
               .entry      (entries[i])
            );
         end
      end
   endgenerate

endmodule

### rtl/top_k_sorted_insert_top.sv
// Top level of the top-k sorted insertion list.
//
// Keeps the SLOTS highest values seen in descending order, each with a time
// stamp. Commands arrive as words on the req_ channel (valid/stall); each
// command produces exactly one result word on the rsp_ channel.
// An add (command 0) places the value in the first slot that is empty or
// holds a smaller value; lower entries move down one cell and the last drops
// off. Adds do nothing while csr tracking_enabled is 0. A read (command 1)
// returns the slot at read_index; an index past the end reads as empty.
// The result is in the output register the cycle after the command is taken.
// Throughput is one command per cycle while the receiver does not stall, set by
// the compare-and-shift in every cell of the slot row.
// When the receiver stalls, the result holds and req_stall rises, so at most
// one result is buffered. Reset empties every slot, clears the count and
// disables tracking; the block takes commands as soon as reset is released.
`timescale 1ns / 1ps
module top_k_sorted_insert_top import tksi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   logic             enabled_ff;
   logic             enabled_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic             accept;
   logic             add_en;
   logic             inserted;
   logic [SLOTS-1:0] take;
   slot_type         entries [SLOTS];
   slot_type         new_entry;
   logic [CNT_W-1:0] pos;
   logic [CNT_W+3:0] pos_ext;
   logic [CNT_W+3:0] count_ext;
   logic [IDX_W+3:0] idx_ext;
   slot_type         rd_entry;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign add_en    = accept && (req_data.command == CMD_ADD) && enabled_ff;
   // the last cell takes whenever any cell does
   assign inserted  = add_en && take[SLOTS-1];

   assign new_entry.valid = 1'b1;
   assign new_entry.value = req_data.new_value;
   assign new_entry.stamp = req_data.new_timestamp;

   tksi_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .add_en    (add_en),
      .new_entry (new_entry),
      .take      (take),
      .entries   (entries)
   );

   // take is a suffix of the row, so the insert slot is the count of non-takers
   always_comb begin
      pos = '0;
      for (int i = 0; i < SLOTS; i++) begin
         pos = pos + {{(CNT_W-1){1'b0}}, ~take[i]};
      end
   end

   assign enabled_in = csr_we ? csr_wdata : enabled_ff;

   always_comb begin
      count_in = count_ff;
      if (inserted && (count_ff != CNT_W'(SLOTS))) begin
         count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end
   end

   assign pos_ext   = {4'b0000, pos};
   assign count_ext = {4'b0000, count_in};
   assign idx_ext   = {{IDX_W{1'b0}}, req_data.read_index};

   always_comb begin
      rd_entry = '0;
      if (idx_ext < (IDX_W + 4)'(SLOTS)) begin
         rd_entry = entries[idx_ext[IDX_W-1:0]];
      end
   end

   always_comb begin
      rsp_data_in                 = '0;
      rsp_data_in.valid_count     = count_ext[3:0];
      if (req_data.command == CMD_READ) begin
         rsp_data_in.entry_value     = rd_entry.value;
         rsp_data_in.entry_timestamp = rd_entry.stamp;
         rsp_data_in.entry_valid     = rd_entry.valid;
      end else if (inserted) begin
         rsp_data_in.was_inserted    = 1'b1;
         rsp_data_in.insert_slot     = pos_ext[3:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enabled_ff   <= enabled_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
